@@ hdl/cptpad_pkg.sv @@
// Shared constants, codes and types of the capacitive pad averaging block.
// Used by every module under hdl; depends on nothing else.

package cptpad_pkg;

   localparam int WINDOW_DEPTH  = 4;
   localparam int PETAL_PAIRS   = 5;

   localparam int PADS_PER_PAIR = 5;
   localparam int BOTTOM_OFFSET = 3;
   localparam int PAD_COUNT     = PADS_PER_PAIR * PETAL_PAIRS;
   localparam int PETAL_COUNT   = 2 * PETAL_PAIRS;

   localparam int SAMPLE_W = 16;
   localparam int PETAL_W  = 4;
   localparam int PADSEL_W = 2;
   localparam int MAP_W    = 10;
   localparam int POSN_W   = SAMPLE_W + 1;

   localparam int POS_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W       = $clog2(WINDOW_DEPTH + 1);
   localparam int SLOT_W      = $clog2(PAD_COUNT);
   localparam int ADDR_W      = $clog2(PAD_COUNT * WINDOW_DEPTH);
   localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_DEPTH);
   localparam int RECIP_SHIFT = SUM_W + CNT_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   localparam int PADDR_W   = 3;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 1;

   localparam logic [REG_IDX_W-1:0] REG_TOP_THR    = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_BOTTOM_THR = REG_IDX_W'(1);

   localparam logic [SAMPLE_W-1:0] TOP_THR_RESET    = 16'd8000;
   localparam logic [SAMPLE_W-1:0] BOTTOM_THR_RESET = 16'd12000;

   // Pad codes; the side code is clockwise on top petals and tip on bottom ones.
   localparam logic [PADSEL_W-1:0] PAD_BASE = 2'd0;
   localparam logic [PADSEL_W-1:0] PAD_SIDE = 2'd1;
   localparam logic [PADSEL_W-1:0] PAD_CCW  = 2'd2;
   localparam logic [PADSEL_W-1:0] PAD_NONE = 2'd3;

   typedef struct packed {
      logic [SAMPLE_W-1:0] top_thr;
      logic [SAMPLE_W-1:0] bottom_thr;
   } cfg_type;

   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] mean;
   } pad_entry_type;

   typedef struct packed {
      logic                smp_rd;
      logic                smp_wr;
      logic [ADDR_W-1:0]   smp_addr;
      logic [SAMPLE_W-1:0] smp_wdata;
      logic                pad_rd;
      logic [SLOT_W-1:0]   pad_rd_slot;
      logic                pad_wr;
      logic [SLOT_W-1:0]   pad_wr_slot;
      pad_entry_type       pad_wdata;
   } store_cmd_type;

endpackage

@@ hdl/cptpad_csr.sv @@
// Threshold registers behind the APB-style configuration port.
// Depends on cptpad_pkg.

module cptpad_csr import cptpad_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready,
   output cfg_type            cfg
);

   logic [SAMPLE_W-1:0]  top_thr_ff, top_thr_in;
   logic [SAMPLE_W-1:0]  bottom_thr_ff, bottom_thr_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[PADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      top_thr_in    = top_thr_ff;
      bottom_thr_in = bottom_thr_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_TOP_THR: begin
               top_thr_in = pwdata[SAMPLE_W-1:0];
            end
            REG_BOTTOM_THR: begin
               bottom_thr_in = pwdata[SAMPLE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_thr_ff    <= TOP_THR_RESET;
         bottom_thr_ff <= BOTTOM_THR_RESET;
      end else begin
         top_thr_ff    <= top_thr_in;
         bottom_thr_ff <= bottom_thr_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_TOP_THR:    prdata = DATA_W'(top_thr_ff);
         REG_BOTTOM_THR: prdata = DATA_W'(bottom_thr_ff);
         default:        prdata = '0;
      endcase
   end

   assign cfg.top_thr    = top_thr_ff;
   assign cfg.bottom_thr = bottom_thr_ff;

endmodule

@@ hdl/cptpad_store.sv @@
// Sample ring memory and per-pad running sum / mean memory.
// Both are synchronous with a registered read port. Depends on cptpad_pkg.

module cptpad_store import cptpad_pkg::*; (
   input  logic                clock,
   input  store_cmd_type       cmd,
   output logic [SAMPLE_W-1:0] smp_rdata,
   output pad_entry_type       pad_rdata
);

   logic [SAMPLE_W-1:0] sample_mem [PAD_COUNT * WINDOW_DEPTH];
   pad_entry_type       pad_mem [PAD_COUNT];

   logic [SAMPLE_W-1:0] smp_rdata_ff;
   pad_entry_type       pad_rdata_ff;

   // Read-first: a read and a write of the same sample entry return the old value.
   always_ff @(posedge clock) begin
      if (cmd.smp_wr) begin
         sample_mem[cmd.smp_addr] <= cmd.smp_wdata;
      end
      if (cmd.smp_rd) begin
         smp_rdata_ff <= sample_mem[cmd.smp_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pad_wr) begin
         pad_mem[cmd.pad_wr_slot] <= cmd.pad_wdata;
      end
      if (cmd.pad_rd) begin
         pad_rdata_ff <= pad_mem[cmd.pad_rd_slot];
      end
   end

   assign smp_rdata = smp_rdata_ff;
   assign pad_rdata = pad_rdata_ff;

endmodule

@@ hdl/cptpad_div.sv @@
// Truncated mean of a ring sum: one registered multiply by a reciprocal table.
// Depends on cptpad_pkg.

module cptpad_div import cptpad_pkg::*; (
   input  logic                clock,
   input  logic                load,
   input  logic [SUM_W-1:0]    sum,
   input  logic [CNT_W-1:0]    count,
   output logic [SAMPLE_W-1:0] quotient
);

   localparam int TAB_DEPTH = 1 << CNT_W;
   localparam int PROD_W    = SUM_W + RECIP_W;

   logic [RECIP_W-1:0] recip_tab [TAB_DEPTH];
   logic [PROD_W-1:0]  prod_ff, prod_in;

   // The reciprocal is rounded up with enough fraction bits that the
   // truncated product equals the integer quotient for every sum and count.
   for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_recip
      localparam longint unsigned DIVISOR = (g >= 1) ? g : 1;
      localparam longint unsigned FULL =
         ((64'd1 << RECIP_SHIFT) + DIVISOR - 64'd1) / DIVISOR;
      assign recip_tab[g] = (g >= 1 && g <= WINDOW_DEPTH) ? RECIP_W'(FULL) : '0;
   end

   always_comb begin
      prod_in = prod_ff;
      if (load) begin
         prod_in = PROD_W'(sum) * PROD_W'(recip_tab[count]);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign quotient = prod_ff[RECIP_SHIFT +: SAMPLE_W];

endmodule

@@ hdl/captouch_pad_average_and_press.sv @@
// Top level of the capacitive pad averaging and press detection block.
// Depends on cptpad_pkg, cptpad_csr, cptpad_store and cptpad_div.
//
//  channel  direction  handshake                  payload
//  req      in         req_valid / req_stall      req_petal, req_pad_select, req_sample
//  rsp      out        rsp_valid / rsp_stall      rsp_ignored, rsp_pad_pressed,
//                                                 rsp_petal_pressed, rsp_pressed_map,
//                                                 rsp_phi, rsp_rad
//  csr      in/out     psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// A valid word passes through S_SUM, S_MUL, S_MEAN, S_COMB and S_FIN after acceptance;
// an ignored word goes straight to S_FIN. No new word is accepted before S_IDLE again.
// The sequence is set by the single read port of the pad sum/mean memory, which
// returns the petal's pad means one per cycle, and by the registered reciprocal multiply.
// Reset is synchronous and clears the sequencer, the ring positions, wrap flags and
// press flags in flip-flops; the memories need no clearing pass.
// A finished word waits in the result register while rsp_stall is high and the
// next word is accepted meanwhile; the sequencer holds in its last state only
// when that register is still occupied.

module captouch_pad_average_and_press import cptpad_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [PETAL_W-1:0]        req_petal,
   input  logic [PADSEL_W-1:0]       req_pad_select,
   input  logic [SAMPLE_W-1:0]       req_sample,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_ignored,
   output logic                      rsp_pad_pressed,
   output logic                      rsp_petal_pressed,
   output logic [MAP_W-1:0]          rsp_pressed_map,
   output logic signed [POSN_W-1:0]  rsp_phi,
   output logic signed [POSN_W-1:0]  rsp_rad,

   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [PADDR_W-1:0]        paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   output logic                      pready
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_SUM  = 6'b000010,
      S_MUL  = 6'b000100,
      S_MEAN = 6'b001000,
      S_COMB = 6'b010000,
      S_FIN  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   cfg_type             cfg;
   store_cmd_type       cmd;
   logic [SAMPLE_W-1:0] smp_rdata;
   pad_entry_type       pad_rdata;
   logic [SAMPLE_W-1:0] quotient;

   // Request decode
   logic              accept;
   logic              req_top;
   logic              req_bad;
   logic [SLOT_W-1:0] req_base;
   logic [SLOT_W-1:0] req_slot;
   logic [ADDR_W-1:0] req_addr;

   // Word in flight
   logic [PETAL_W-1:0]  petal_ff;
   logic [PADSEL_W-1:0] pad_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                top_ff;
   logic                bad_ff;
   logic [SLOT_W-1:0]   base_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [POS_W-1:0]    own_pos_ff;
   logic                own_wrap_ff;

   logic                own_last;
   logic                own_filled;
   logic [POS_W-1:0]    pos_next;
   logic                wrap_next;
   logic [CNT_W-1:0]    cnt_new;
   logic                pressed;

   logic [SUM_W-1:0]    sum_ff;
   logic [SAMPLE_W-1:0] mean_own_ff;
   logic [SAMPLE_W-1:0] mean_base_ff;
   logic [SAMPLE_W-1:0] mean_side_ff;
   logic [SAMPLE_W-1:0] mean_ccw_ff;
   logic                rd_filled_ff, rd_filled_in;
   logic [SAMPLE_W-1:0] role_mean;

   // Per-pad ring state
   logic [POS_W-1:0]     ring_pos_ff [PAD_COUNT];
   logic [POS_W-1:0]     ring_pos_in [PAD_COUNT];
   logic [PAD_COUNT-1:0] ring_wrap_ff, ring_wrap_in;
   logic [PAD_COUNT-1:0] press_ff, press_in;

   // Result assembly
   logic [(1 << PETAL_W)-1:0] petal_vec;
   logic [SAMPLE_W-1:0]       m_base, m_side, m_ccw;
   logic [POSN_W-1:0]         side_sum;
   logic [POSN_W-1:0]         phi_c, rad_c;
   logic                      out_free;
   logic                      load_out;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ignored_ff;
   logic                rsp_pad_pressed_ff;
   logic                rsp_petal_pressed_ff;
   logic [MAP_W-1:0]    rsp_pressed_map_ff;
   logic [POSN_W-1:0]   rsp_phi_ff;
   logic [POSN_W-1:0]   rsp_rad_ff;

   cptpad_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cptpad_store u_store (
      .clock     (clock),
      .cmd       (cmd),
      .smp_rdata (smp_rdata),
      .pad_rdata (pad_rdata)
   );

   cptpad_div u_div (
      .clock    (clock),
      .load     (state_ff == S_MUL),
      .sum      (sum_ff),
      .count    (cnt_new),
      .quotient (quotient)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_top  = !req_petal[0];
      req_bad  = (int'(req_petal) >= PETAL_COUNT) || (req_pad_select == PAD_NONE) ||
                 (!req_top && req_pad_select == PAD_CCW);
      req_base = req_bad ? '0 :
                 SLOT_W'(int'(req_petal >> 1) * PADS_PER_PAIR +
                         (req_top ? 0 : BOTTOM_OFFSET));
      req_slot = req_bad ? '0 : SLOT_W'(int'(req_base) + int'(req_pad_select));
      req_addr = ADDR_W'(int'(req_slot) * WINDOW_DEPTH + int'(ring_pos_ff[req_slot]));
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         petal_ff    <= req_petal;
         pad_ff      <= req_pad_select;
         sample_ff   <= req_sample;
         top_ff      <= req_top;
         bad_ff      <= req_bad;
         base_ff     <= req_base;
         slot_ff     <= req_slot;
         addr_ff     <= req_addr;
         own_pos_ff  <= ring_pos_ff[req_slot];
         own_wrap_ff <= ring_wrap_ff[req_slot];
      end
   end

   always_comb begin
      own_last   = (own_pos_ff == POS_W'(WINDOW_DEPTH - 1));
      own_filled = own_wrap_ff || (own_pos_ff != '0);
      pos_next   = own_last ? '0 : own_pos_ff + 1'b1;
      wrap_next  = own_wrap_ff || own_last;
      cnt_new    = wrap_next ? CNT_W'(WINDOW_DEPTH) : CNT_W'(pos_next);
      pressed    = sample_ff > (top_ff ? cfg.top_thr : cfg.bottom_thr);
   end

   // Once the ring has wrapped, the entry being overwritten leaves the sum.
   always_ff @(posedge clock) begin
      if (state_ff == S_SUM) begin
         sum_ff <= (own_filled ? pad_rdata.sum : '0) -
                   (own_wrap_ff ? SUM_W'(smp_rdata) : '0) + SUM_W'(sample_ff);
      end
   end

   // Memory sequencing: own entries at acceptance, then the petal's pads in order
   // base, side, counter-clockwise (top petals only), with the write-back in S_MEAN.
   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            cmd.smp_rd      = accept && !req_bad;
            cmd.smp_addr    = req_addr;
            cmd.pad_rd      = accept && !req_bad;
            cmd.pad_rd_slot = req_slot;
         end
         S_SUM: begin
            cmd.pad_rd      = 1'b1;
            cmd.pad_rd_slot = base_ff;
         end
         S_MUL: begin
            cmd.pad_rd      = 1'b1;
            cmd.pad_rd_slot = base_ff + SLOT_W'(1);
         end
         S_MEAN: begin
            cmd.pad_rd         = top_ff;
            cmd.pad_rd_slot    = top_ff ? base_ff + SLOT_W'(2) : '0;
            cmd.smp_wr         = 1'b1;
            cmd.smp_addr       = addr_ff;
            cmd.smp_wdata      = sample_ff;
            cmd.pad_wr         = 1'b1;
            cmd.pad_wr_slot    = slot_ff;
            cmd.pad_wdata.sum  = sum_ff;
            cmd.pad_wdata.mean = quotient;
         end
         default: begin
         end
      endcase
   end

   // An empty ring has mean zero, and its memory entry may never have been written.
   assign rd_filled_in = ring_wrap_ff[cmd.pad_rd_slot] || (ring_pos_ff[cmd.pad_rd_slot] != '0);
   assign role_mean    = rd_filled_ff ? pad_rdata.mean : '0;

   always_ff @(posedge clock) begin
      rd_filled_ff <= rd_filled_in;
      case (state_ff)
         S_MUL: begin
            mean_base_ff <= role_mean;
         end
         S_MEAN: begin
            mean_side_ff <= role_mean;
            mean_own_ff  <= quotient;
         end
         S_COMB: begin
            mean_ccw_ff <= top_ff ? role_mean : '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ring_pos_in  = ring_pos_ff;
      ring_wrap_in = ring_wrap_ff;
      press_in     = press_ff;
      if (state_ff == S_MEAN) begin
         ring_pos_in[slot_ff]  = pos_next;
         ring_wrap_in[slot_ff] = wrap_next;
         press_in[slot_ff]     = pressed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_pos_ff  <= '{default: '0};
         ring_wrap_ff <= '0;
         press_ff     <= '0;
      end else begin
         ring_pos_ff  <= ring_pos_in;
         ring_wrap_ff <= ring_wrap_in;
         press_ff     <= press_in;
      end
   end

   always_comb begin
      petal_vec = '0;
      for (int p = 0; p < PETAL_COUNT; p++) begin
         if ((p & 1) == 0) begin
            petal_vec[p] = press_ff[(p >> 1) * PADS_PER_PAIR] ||
                           press_ff[(p >> 1) * PADS_PER_PAIR + 1] ||
                           press_ff[(p >> 1) * PADS_PER_PAIR + 2];
         end else begin
            petal_vec[p] = press_ff[(p >> 1) * PADS_PER_PAIR + BOTTOM_OFFSET] ||
                           press_ff[(p >> 1) * PADS_PER_PAIR + BOTTOM_OFFSET + 1];
         end
      end
   end

   // The written pad's mean comes from the divider; the memory read of it is stale.
   always_comb begin
      m_base   = (pad_ff == PAD_BASE) ? mean_own_ff : mean_base_ff;
      m_side   = (pad_ff == PAD_SIDE) ? mean_own_ff : mean_side_ff;
      m_ccw    = (pad_ff == PAD_CCW)  ? mean_own_ff : mean_ccw_ff;
      side_sum = {1'b0, m_side} + {1'b0, m_ccw};
      if (bad_ff) begin
         phi_c = '0;
         rad_c = '0;
      end else if (top_ff) begin
         phi_c = {1'b0, m_ccw} - {1'b0, m_side};
         rad_c = {1'b0, side_sum[POSN_W-1:1]} - {1'b0, m_base};
      end else begin
         phi_c = '0;
         rad_c = {1'b0, m_side} - {1'b0, m_base};
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_out = (state_ff == S_FIN) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_bad ? S_FIN : S_SUM;
            end
         end
         S_SUM:  state_in = S_MUL;
         S_MUL:  state_in = S_MEAN;
         S_MEAN: state_in = S_COMB;
         S_COMB: state_in = S_FIN;
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ignored_ff       <= bad_ff;
         rsp_pad_pressed_ff   <= !bad_ff && pressed;
         rsp_petal_pressed_ff <= !bad_ff && petal_vec[petal_ff];
         rsp_pressed_map_ff   <= petal_vec[MAP_W-1:0];
         rsp_phi_ff           <= phi_c;
         rsp_rad_ff           <= rad_c;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ignored       = rsp_ignored_ff;
   assign rsp_pad_pressed   = rsp_pad_pressed_ff;
   assign rsp_petal_pressed = rsp_petal_pressed_ff;
   assign rsp_pressed_map   = rsp_pressed_map_ff;
   assign rsp_phi           = $signed(rsp_phi_ff);
   assign rsp_rad           = $signed(rsp_rad_ff);

   // A valid word walks the memory sequence without gaps.
   a_sequence: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |=> (state_ff == S_MUL) ##1 (state_ff == S_MEAN)
                              ##1 (state_ff == S_COMB))
      else $error("memory access sequence broken");

   // A pressed pad always makes its petal pressed.
   a_pad_implies_petal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ignored && rsp_pad_pressed) |-> rsp_petal_pressed)
      else $error("pad pressed without petal pressed");

   // An ignored word carries nothing but the pressed map.
   a_ignored_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ignored) |->
         (rsp_phi == '0 && rsp_rad == '0 && !rsp_pad_pressed && !rsp_petal_pressed))
      else $error("ignored word carries position or press data");

   // Ring state changes only in the write-back step.
   a_ring_write_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_MEAN) |=> $stable(press_ff) && $stable(ring_wrap_ff))
      else $error("ring state changed outside write-back");

endmodule

@@ tb/captouch_pad_average_and_press_tb.sv @@
// Self-checking testbench for captouch_pad_average_and_press: drives sample words and
// threshold writes, predicts each result word and compares it field by field.
// Depends on cptpad_pkg and the captouch_pad_average_and_press RTL.
`timescale 1ns / 1ps

module captouch_pad_average_and_press_tb import cptpad_pkg::*;;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic                       ignored;
      logic                       pad_pressed;
      logic                       petal_pressed;
      logic [MAP_W-1:0]           pressed_map;
      logic signed [POSN_W-1:0]   phi;
      logic signed [POSN_W-1:0]   rad;
   } touch_report_type;

   logic clock = 1'b0;
   logic reset;

   logic                       req_valid;
   logic                       req_stall;
   logic [PETAL_W-1:0]         req_petal;
   logic [PADSEL_W-1:0]        req_pad_select;
   logic [SAMPLE_W-1:0]        req_sample;

   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_ignored;
   logic                       rsp_pad_pressed;
   logic                       rsp_petal_pressed;
   logic [MAP_W-1:0]           rsp_pressed_map;
   logic signed [POSN_W-1:0]   rsp_phi;
   logic signed [POSN_W-1:0]   rsp_rad;

   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [PADDR_W-1:0]         paddr;
   logic [DATA_W-1:0]          pwdata;
   logic [DATA_W-1:0]          prdata;
   logic                       pready;

   // Mirror of the block's pad rings, press flags and thresholds.
   logic [SAMPLE_W-1:0] ring_samples [PAD_COUNT][WINDOW_DEPTH];
   int unsigned         ring_next [PAD_COUNT];
   bit                  ring_full [PAD_COUNT];
   bit                  pad_down [PAD_COUNT];
   logic [SAMPLE_W-1:0] top_thr_model    = TOP_THR_RESET;
   logic [SAMPLE_W-1:0] bottom_thr_model = BOTTOM_THR_RESET;

   touch_report_type touch_reports_due [$];
   touch_report_type report_want;

   bit gaps_on;
   bit stalls_on;
   int hold_requests;
   int cycle_count;
   int errors;
   int words_sent;
   int ignored_sent;
   int results_checked;
   int settings_used;
   bit last_ignored;

   captouch_pad_average_and_press i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_petal         (req_petal),
      .req_pad_select    (req_pad_select),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ignored       (rsp_ignored),
      .rsp_pad_pressed   (rsp_pad_pressed),
      .rsp_petal_pressed (rsp_petal_pressed),
      .rsp_pressed_map   (rsp_pressed_map),
      .rsp_phi           (rsp_phi),
      .rsp_rad           (rsp_rad),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("captouch_pad_average_and_press: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Truncated mean over the filled entries of one pad ring; an empty ring gives 0.
   function automatic int unsigned pad_mean(input int unsigned slot);
      int unsigned n;
      int unsigned total;
      n = ring_full[slot] ? WINDOW_DEPTH : ring_next[slot];
      total = 0;
      if (n == 0)
         return 0;
      for (int i = 0; i < n; i++)
         total += ring_samples[slot][i];
      return total / n;
   endfunction

   function automatic bit petal_down(input int unsigned petal);
      int unsigned base;
      base = (petal / 2) * PADS_PER_PAIR;
      if (petal % 2 == 0)
         return pad_down[base + PAD_BASE] | pad_down[base + PAD_SIDE] | pad_down[base + PAD_CCW];
      return pad_down[base + BOTTOM_OFFSET + PAD_BASE] | pad_down[base + BOTTOM_OFFSET + PAD_SIDE];
   endfunction

   function automatic logic [MAP_W-1:0] petal_map();
      logic [MAP_W-1:0] map;
      map = '0;
      for (int p = 0; p < PETAL_COUNT && p < MAP_W; p++)
         map[p] = petal_down(p);
      return map;
   endfunction

   // Updates the mirrored state for one accepted word and returns its result word.
   function automatic touch_report_type apply_touch_sample(input logic [PETAL_W-1:0] petal,
                                                           input logic [PADSEL_W-1:0] pad,
                                                           input logic [SAMPLE_W-1:0] sample);
      touch_report_type r;
      bit top;
      int unsigned base;
      int unsigned slot;
      int ccw;
      int cw;
      int bm;
      int tip;
      logic [SAMPLE_W-1:0] thr;
      r = '0;
      top = (petal[0] == 1'b0);
      if (petal >= PETAL_COUNT || pad == PAD_NONE || (!top && pad == PAD_CCW)) begin
         r.ignored = 1'b1;
         r.pressed_map = petal_map();
         return r;
      end
      base = (petal / 2) * PADS_PER_PAIR;
      slot = top ? base + pad : base + BOTTOM_OFFSET + pad;
      ring_samples[slot][ring_next[slot]] = sample;
      ring_next[slot]++;
      if (ring_next[slot] >= WINDOW_DEPTH) begin
         ring_next[slot] = 0;
         ring_full[slot] = 1'b1;
      end
      thr = top ? top_thr_model : bottom_thr_model;
      r.pad_pressed = (sample > thr);
      pad_down[slot] = r.pad_pressed;
      if (top) begin
         ccw = int'(pad_mean(base + PAD_CCW));
         cw = int'(pad_mean(base + PAD_SIDE));
         bm = int'(pad_mean(base + PAD_BASE));
         r.phi = POSN_W'(ccw - cw);
         r.rad = POSN_W'((ccw + cw) / 2 - bm);
      end else begin
         tip = int'(pad_mean(base + BOTTOM_OFFSET + PAD_SIDE));
         bm = int'(pad_mean(base + BOTTOM_OFFSET + PAD_BASE));
         r.rad = POSN_W'(tip - bm);
      end
      r.petal_pressed = petal_down(petal);
      r.pressed_map = petal_map();
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (touch_reports_due.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing pending", $time);
         end else begin
            report_want = touch_reports_due.pop_front();
            check_field("ignored", 32'(report_want.ignored), 32'(rsp_ignored));
            check_field("pad_pressed", 32'(report_want.pad_pressed), 32'(rsp_pad_pressed));
            check_field("petal_pressed", 32'(report_want.petal_pressed),
                        32'(rsp_petal_pressed));
            check_field("pressed_map", 32'(report_want.pressed_map), 32'(rsp_pressed_map));
            check_field("phi", 32'(report_want.phi), 32'(rsp_phi));
            check_field("rad", 32'(report_want.rad), 32'(rsp_rad));
            results_checked++;
         end
      end
   end

   // Result side stall: random runs, or one long hold-off on request.
   initial begin
      int run_left;
      int hold_left;
      int holds_seen;
      bit level;
      int pick;
      rsp_stall = 1'b0;
      run_left = 0;
      hold_left = 0;
      holds_seen = 0;
      level = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!stalls_on) begin
            rsp_stall <= 1'b0;
         end else begin
            if (run_left == 0) begin
               pick = $urandom_range(0, 9);
               if (pick <= 5) begin
                  level = 1'b0;
                  run_left = $urandom_range(1, 8);
               end else if (pick <= 8) begin
                  level = 1'b1;
                  run_left = $urandom_range(1, 3);
               end else begin
                  level = 1'b1;
                  run_left = $urandom_range(15, 60);
               end
            end
            run_left--;
            rsp_stall <= level;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus tasks; each is entered and left just after a falling edge.
   // ------------------------------------------------------------------

   task automatic send_touch_word(input logic [PETAL_W-1:0] petal,
                                  input logic [PADSEL_W-1:0] pad,
                                  input logic [SAMPLE_W-1:0] sample,
                                  output bit was_ignored);
      int gap;
      int pick;
      touch_report_type r;
      gap = 0;
      if (gaps_on) begin
         pick = $urandom_range(0, 19);
         if (pick >= 18)
            gap = $urandom_range(8, 40);
         else if (pick >= 12)
            gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_petal <= petal;
      req_pad_select <= pad;
      req_sample <= sample;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      r = apply_touch_sample(petal, pad, sample);
      touch_reports_due.push_back(r);
      was_ignored = r.ignored;
      words_sent++;
      if (r.ignored)
         ignored_sent++;
      @(negedge clock);
   endtask

   // Waits until every pending result word is out and the block has settled.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (touch_reports_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes one threshold register and reads it back.
   task automatic set_threshold(input logic [REG_IDX_W-1:0] idx, input logic [15:0] value);
      logic [DATA_W-1:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_W'(4 * idx);
      pwdata <= DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_TOP_THR:    top_thr_model = value;
         REG_BOTTOM_THR: bottom_thr_model = value;
         default: ;
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (got[15:0] !== value) begin
         errors++;
         $display("%0t: register %0d read expected %h, got %h", $time, idx, value, got[15:0]);
      end
      @(negedge clock);
   endtask

   // Threshold boundaries at the reset values, extremes of every field and bad pads.
   task automatic test_directed_levels();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      send_touch_word(4'd0, PAD_BASE, 16'd0, last_ignored);
      send_touch_word(4'd0, PAD_SIDE, 16'hFFFF, last_ignored);
      send_touch_word(4'd0, PAD_CCW, 16'd8000, last_ignored);
      send_touch_word(4'd0, PAD_CCW, 16'd8001, last_ignored);
      send_touch_word(4'd1, PAD_BASE, 16'd12000, last_ignored);
      send_touch_word(4'd1, PAD_SIDE, 16'd12001, last_ignored);
      // A counter-clockwise pad on a bottom petal and the unused pad code are dropped.
      send_touch_word(4'd1, PAD_CCW, 16'd500, last_ignored);
      send_touch_word(4'd1, PAD_NONE, 16'hFFFF, last_ignored);
      send_touch_word(4'd0, PAD_NONE, 16'hFFFF, last_ignored);
      send_touch_word(4'd9, PAD_SIDE, 16'hFFFF, last_ignored);
      send_touch_word(4'd8, PAD_CCW, 16'd0, last_ignored);
      send_touch_word(4'd10, PAD_BASE, 16'hFFFF, last_ignored);
      send_touch_word(4'd15, PAD_NONE, 16'hFFFF, last_ignored);
      send_touch_word(4'd14, PAD_SIDE, 16'd1, last_ignored);
   endtask

   // Fills rings past one full turn so the mean switches from partial to full windows.
   task automatic test_ring_wrap();
      send_touch_word(4'd2, PAD_SIDE, 16'd100, last_ignored);
      send_touch_word(4'd2, PAD_SIDE, 16'd200, last_ignored);
      send_touch_word(4'd2, PAD_SIDE, 16'd301, last_ignored);
      send_touch_word(4'd2, PAD_SIDE, 16'd400, last_ignored);
      send_touch_word(4'd2, PAD_SIDE, 16'd1000, last_ignored);
      send_touch_word(4'd2, PAD_CCW, 16'hFFFF, last_ignored);
      send_touch_word(4'd2, PAD_BASE, 16'd3, last_ignored);
      send_touch_word(4'd3, PAD_SIDE, 16'd7, last_ignored);
      send_touch_word(4'd3, PAD_SIDE, 16'hFFFF, last_ignored);
      send_touch_word(4'd3, PAD_BASE, 16'hFFFF, last_ignored);
   endtask

   // Random words under one pair of thresholds; count is the number of valid words.
   task automatic test_threshold_phase(input logic [15:0] top_thr, input logic [15:0] bottom_thr,
                                       input int count, input bit idle_on);
      int valid_sent;
      int thr;
      int pick;
      logic [PETAL_W-1:0] petal;
      logic [PADSEL_W-1:0] pad;
      logic [SAMPLE_W-1:0] sample;
      bit dropped;
      drain_results();
      set_threshold(REG_TOP_THR, top_thr);
      set_threshold(REG_BOTTOM_THR, bottom_thr);
      settings_used++;
      gaps_on = idle_on;
      stalls_on = idle_on;
      valid_sent = 0;
      while (valid_sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            petal = PETAL_W'($urandom_range(0, 15));
            pad = PADSEL_W'($urandom_range(0, 3));
         end else begin
            petal = PETAL_W'($urandom_range(0, PETAL_COUNT - 1));
            pad = PADSEL_W'(petal[0] ? $urandom_range(0, 1) : $urandom_range(0, 2));
         end
         thr = petal[0] ? int'(bottom_thr_model) : int'(top_thr_model);
         pick = $urandom_range(0, 7);
         if (pick == 0) begin
            sample = $urandom_range(0, 1) ? '1 : '0;
         end else if (pick <= 2) begin
            // Land right around the threshold to exercise the strict comparison.
            thr = thr + int'($urandom_range(0, 4)) - 2;
            if (thr < 0)
               thr = 0;
            if (thr > 65535)
               thr = 65535;
            sample = SAMPLE_W'(thr);
         end else begin
            sample = SAMPLE_W'($urandom());
         end
         send_touch_word(petal, pad, sample, dropped);
         if (!dropped)
            valid_sent++;
      end
   endtask

   // Holds off the result side for a long stretch while words keep coming.
   task automatic test_result_backpressure();
      logic [PETAL_W-1:0] petal;
      drain_results();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      hold_requests++;
      for (int i = 0; i < 40; i++) begin
         petal = PETAL_W'($urandom_range(0, PETAL_COUNT - 1));
         send_touch_word(petal,
                         PADSEL_W'(petal[0] ? $urandom_range(0, 1) : $urandom_range(0, 2)),
                         SAMPLE_W'($urandom()), last_ignored);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_petal = '0;
      req_pad_select = '0;
      req_sample = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      hold_requests = 0;
      cycle_count = 0;
      errors = 0;
      words_sent = 0;
      ignored_sent = 0;
      results_checked = 0;
      settings_used = 1;
      for (int s = 0; s < PAD_COUNT; s++) begin
         ring_next[s] = 0;
         ring_full[s] = 1'b0;
         pad_down[s] = 1'b0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_levels();
      test_ring_wrap();
      test_threshold_phase(16'd0, 16'd0, 110, 1'b1);
      test_threshold_phase(16'hFFFF, 16'hFFFF, 110, 1'b0);
      test_threshold_phase(16'd8000, 16'd12000, 110, 1'b1);
      test_result_backpressure();
      test_threshold_phase(16'($urandom()), 16'($urandom()), 110, 1'b1);
      test_threshold_phase(16'd500, 16'd60000, 110, 1'b1);
      test_threshold_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           110, 1'b0);

      drain_results();
      $display("Run covered %0d sample words (%0d ignored) over %0d threshold settings,",
               words_sent, ignored_sent, settings_used);
      $display("with random idling, a long result hold-off and %0d result words checked.",
               results_checked);
      if (errors == 0 && touch_reports_due.size() == 0) begin
         $display("captouch_pad_average_and_press: match");
      end else begin
         $display("captouch_pad_average_and_press: mismatch");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/cptpad_pkg.sv
hdl/cptpad_csr.sv
hdl/cptpad_store.sv
hdl/cptpad_div.sv
hdl/captouch_pad_average_and_press.sv
tb/captouch_pad_average_and_press_tb.sv
